>>> rtl/mwsched_pkg.sv
package mwsched_pkg;

  localparam int unsigned COUNT_WIDTH   = 16;
  localparam int unsigned BACKOFF_STEPS = 7;

  localparam int unsigned REG_W      = 16;
  localparam int unsigned DIV_W      = 16;
  localparam int unsigned CMP_W      = (COUNT_WIDTH > DIV_W) ? COUNT_WIDTH : DIV_W;
  localparam int unsigned NUM_CNT    = 5;
  localparam int unsigned TABLE_LEN  = 7;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned OVR_W      = 13;
  localparam int unsigned BIDX_W     = 3;
  localparam int unsigned STEPS_RAW  =
    (BACKOFF_STEPS < TABLE_LEN) ? BACKOFF_STEPS : TABLE_LEN;
  localparam int unsigned STEPS_USED = (STEPS_RAW == 0) ? 1 : STEPS_RAW;

  typedef logic [2:0] cidx_t;

  localparam cidx_t CNT_FULL  = 3'd0;
  localparam cidx_t CNT_SNOOZE = 3'd1;
  localparam cidx_t CNT_ENVSND = 3'd2;
  localparam cidx_t CNT_ALERT = 3'd3;
  localparam cidx_t CNT_ENVLOG = 3'd4;

  localparam logic [2:0] REG_WAKE_UNIT = 3'd0;
  localparam logic [2:0] REG_FULL_INT  = 3'd1;
  localparam logic [2:0] REG_SNOOZE    = 3'd2;
  localparam logic [2:0] REG_ENV_SEND  = 3'd3;
  localparam logic [2:0] REG_ALERT     = 3'd4;
  localparam logic [2:0] REG_ENV_LOG   = 3'd5;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_COLD    = 2'd1;
  localparam logic [1:0] FUNC_ANOMALY = 2'd2;

  localparam logic [2:0] KIND_LINK_FAIL = 3'd0;
  localparam logic [2:0] KIND_EMPTY     = 3'd1;
  localparam logic [2:0] KIND_IN_MOTION = 3'd2;
  localparam logic [2:0] KIND_SHORT_IGN = 3'd3;
  localparam logic [2:0] KIND_LOW_BATT  = 3'd4;
  localparam logic [2:0] KIND_CHG_REM   = 3'd5;
  localparam logic [2:0] KIND_SHUTDOWN  = 3'd6;

  localparam logic [2:0] WR_NORMAL   = 3'd0;
  localparam logic [2:0] WR_FULL     = 3'd1;
  localparam logic [2:0] WR_SNOOZE   = 3'd2;
  localparam logic [2:0] WR_ENV_SEND = 3'd3;
  localparam logic [2:0] WR_ALERT    = 3'd4;
  localparam logic [2:0] WR_ENV_LOG  = 3'd5;
  localparam logic [2:0] WR_SLEEP    = 3'd6;

  localparam logic [1:0] PA_NONE  = 2'd0;
  localparam logic [1:0] PA_SLEEP = 2'd1;
  localparam logic [1:0] PA_OFF   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // backoff sleep time in seconds
  function automatic logic [OVR_W-1:0] backoff_seconds(input logic [BIDX_W-1:0] sel);
    logic [7:0] minutes;
    logic [15:0] secs;
    case (sel)
      3'd0: minutes = 8'd2;
      3'd1: minutes = 8'd4;
      3'd2: minutes = 8'd8;
      3'd3: minutes = 8'd16;
      3'd4: minutes = 8'd32;
      3'd5: minutes = 8'd60;
      3'd6: minutes = 8'd120;
      default: minutes = 8'd0;
    endcase
    secs = 16'(SEC_PER_MIN) * 16'(minutes);
    return secs[OVR_W-1:0];
  endfunction

endpackage

>>> rtl/mwsched_div.sv
module mwsched_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mwsched_pkg::DIV_W-1:0]   dividend_i,
  input  logic [mwsched_pkg::DIV_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [mwsched_pkg::DIV_W-1:0]   quotient_o
);
  import mwsched_pkg::*;

  localparam int unsigned CW = $clog2(DIV_W);
  localparam logic [CW-1:0] LAST = CW'(DIV_W - 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             ge;

  // one restoring step a cycle, zero divisor gives all ones
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    diff   = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/multi_interval_wake_scheduler.sv
// one word at a time: a tick's result is valid once each threshold tested has been through
// the 16-step serial divider shared by the thresholds
// cold reset, anomaly and other words skip the divider and go straight to the output state
// s_axis_tready returns in the same cycle that a word's result is registered, after any
// wait for the output register to drain
// rst_ni clears counters, backoff, override and loads the register defaults
module multi_interval_wake_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // anomaly_kind[2:0], zero fill
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // wake_reason[2:0], power_action[4:3],
                                      // current_full_interval[20:5], zero fill
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [mwsched_pkg::REG_W-1:0] cfg_wdata_i
);
  import mwsched_pkg::*;

  logic [REG_W-1:0] wake_unit_q, full_int_q, snooze_int_q, env_send_int_q;
  logic [REG_W-1:0] alert_int_q, env_log_int_q;

  logic [COUNT_WIDTH-1:0] cnt_q [NUM_CNT];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_CNT];
  logic [BIDX_W-1:0]      bidx_q, bidx_d;
  logic                   ovr_valid_q, ovr_valid_d;
  logic [OVR_W-1:0]       ovr_int_q, ovr_int_d;

  state_e      state_q, state_d;
  cidx_t       idx_q, idx_d;
  logic [2:0]  reason_q, reason_d;
  logic [1:0]  action_q, action_d;

  logic        m_valid_q, m_valid_d;
  logic [23:0] m_data_q, m_data_d;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_quo;
  logic [REG_W-1:0] cur_full;
  logic [REG_W-1:0] sel_int;
  logic [COUNT_WIDTH-1:0] sel_cnt;
  logic [CMP_W-1:0] thr_x, cnt_x;
  logic             hit;
  logic             in_acc;
  logic [BIDX_W-1:0] bsel;
  logic [1:0]       func;
  logic [2:0]       kind;

  assign func     = s_axis_tuser;
  assign kind     = s_axis_tdata[2:0];
  assign cur_full = ovr_valid_q ? REG_W'(ovr_int_q) : full_int_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_unit_q    <= REG_W'(30);
      full_int_q     <= REG_W'(300);
      snooze_int_q   <= REG_W'(600);
      env_send_int_q <= REG_W'(3600);
      alert_int_q    <= REG_W'(600);
      env_log_int_q  <= REG_W'(900);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAKE_UNIT: wake_unit_q    <= cfg_wdata_i;
        REG_FULL_INT:  full_int_q     <= cfg_wdata_i;
        REG_SNOOZE:    snooze_int_q   <= cfg_wdata_i;
        REG_ENV_SEND:  env_send_int_q <= cfg_wdata_i;
        REG_ALERT:     alert_int_q    <= cfg_wdata_i;
        REG_ENV_LOG:   env_log_int_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx_q)
      CNT_FULL:   sel_int = cur_full;
      CNT_SNOOZE: sel_int = snooze_int_q;
      CNT_ENVSND: sel_int = env_send_int_q;
      CNT_ALERT:  sel_int = alert_int_q;
      CNT_ENVLOG: sel_int = env_log_int_q;
      default:    sel_int = '0;
    endcase
  end

  assign sel_cnt = cnt_q[idx_q];
  assign thr_x   = CMP_W'(div_quo);
  assign cnt_x   = CMP_W'(sel_cnt);
  assign hit     = (idx_q == CNT_ENVLOG) ? (thr_x == cnt_x) : (thr_x <= cnt_x);

  mwsched_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sel_int),
    .divisor_i  (wake_unit_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    reason_d    = reason_q;
    action_d    = action_q;
    bidx_d      = bidx_q;
    ovr_valid_d = ovr_valid_q;
    ovr_int_d   = ovr_int_q;
    cnt_d       = cnt_q;
    div_start   = 1'b0;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    bsel        = bidx_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          reason_d = WR_NORMAL;
          action_d = PA_NONE;
          state_d  = ST_OUT;
          case (func)
            FUNC_TICK: begin
              for (int i = 0; i < NUM_CNT; i++) begin
                cnt_d[i] = cnt_q[i] + 1'b1;
              end
              idx_d   = CNT_FULL;
              state_d = ST_LOAD;
            end
            FUNC_COLD: begin
              for (int i = 0; i < NUM_CNT; i++) begin
                cnt_d[i] = '0;
              end
              bidx_d      = '0;
              ovr_valid_d = 1'b0;
              ovr_int_d   = '0;
            end
            FUNC_ANOMALY: begin
              if (32'(bidx_q) < STEPS_USED) begin
                bsel   = bidx_q;
                bidx_d = bidx_q + 1'b1;
              end else begin
                bsel = BIDX_W'(STEPS_USED - 1);
              end
              ovr_int_d   = backoff_seconds(bsel);
              ovr_valid_d = 1'b1;
              case (kind)
                KIND_LINK_FAIL, KIND_IN_MOTION: begin
                  for (int i = 0; i < NUM_CNT; i++) begin
                    cnt_d[i] = '0;
                  end
                  reason_d = WR_SLEEP;
                  action_d = PA_SLEEP;
                end
                KIND_EMPTY, KIND_SHORT_IGN, KIND_LOW_BATT, KIND_CHG_REM,
                KIND_SHUTDOWN: begin
                  action_d = PA_OFF;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (hit) begin
            state_d  = ST_OUT;
            reason_d = 3'(idx_q) + 3'd1;
            action_d = PA_NONE;
            for (int i = 0; i < NUM_CNT; i++) begin
              if (idx_q == CNT_ENVLOG) begin
                if (cidx_t'(i) == CNT_ENVLOG) cnt_d[i] = '0;
              end else if (idx_q != CNT_ALERT) begin
                if (cidx_t'(i) >= idx_q) cnt_d[i] = '0;
              end
            end
          end else if (idx_q == CNT_ENVLOG) begin
            state_d  = ST_OUT;
            reason_d = WR_SLEEP;
            action_d = PA_SLEEP;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, cur_full, action_q, reason_q};
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= CNT_FULL;
      bidx_q      <= '0;
      ovr_valid_q <= 1'b0;
      ovr_int_q   <= '0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      bidx_q      <= bidx_d;
      ovr_valid_q <= ovr_valid_d;
      ovr_int_q   <= ovr_int_d;
      m_valid_q   <= m_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reason_q <= reason_d;
    action_q <= action_d;
    m_data_q <= m_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> sim/multi_interval_wake_scheduler_tb.sv
module multi_interval_wake_scheduler_tb;
  import mwsched_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES = 15;
  localparam int unsigned WORDS_PER_PHASE = 102;
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam int unsigned NUM_REGS = 6;

  localparam logic [1:0] FUNC_IGNORED = 2'd3;
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_UNUSED  = 3'd7;

  localparam int unsigned NAP_MINUTES [TABLE_LEN] = '{2, 4, 8, 16, 32, 60, 120};

  typedef struct packed {
    logic [2:0]  reason;
    logic [1:0]  action;
    logic [15:0] full_ivl;
  } wake_result_t;

  typedef struct packed {
    logic [1:0]   func;
    logic [2:0]   kind;
    logic         typed;
    wake_result_t want;
  } plan_row_t;

  localparam wake_result_t ANY = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_wdata_i = '0;

  multi_interval_wake_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // scheduler state mirror
  logic [15:0]            reg_val  [NUM_REGS];
  logic [15:0]            next_reg [NUM_REGS];
  logic [COUNT_WIDTH-1:0] wake_cnt [NUM_CNT];
  logic [BIDX_W-1:0]      nap_idx;
  logic                   ovr_on;
  logic [OVR_W-1:0]       ovr_secs;

  wake_result_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;

  function automatic logic [15:0] ticks_for(logic [15:0] secs);
    if (reg_val[REG_WAKE_UNIT] == 16'd0) begin
      return 16'hFFFF;
    end
    return secs / reg_val[REG_WAKE_UNIT];
  endfunction

  function automatic logic [15:0] full_now();
    return ovr_on ? 16'(ovr_secs) : reg_val[REG_FULL_INT];
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < NUM_CNT; i++) wake_cnt[i] = '0;
  endfunction

  function automatic void reset_schedule();
    reg_val[REG_WAKE_UNIT] = 16'd30;
    reg_val[REG_FULL_INT]  = 16'd300;
    reg_val[REG_SNOOZE]    = 16'd600;
    reg_val[REG_ENV_SEND]  = 16'd3600;
    reg_val[REG_ALERT]     = 16'd600;
    reg_val[REG_ENV_LOG]   = 16'd900;
    clear_counts();
    nap_idx  = '0;
    ovr_on   = 1'b0;
    ovr_secs = '0;
  endfunction

  function automatic wake_result_t advance_schedule(logic [1:0] func, logic [2:0] kind);
    wake_result_t res;
    int unsigned sel;
    res.reason = WR_NORMAL;
    res.action = PA_NONE;
    case (func)
      FUNC_TICK: begin
        for (int i = 0; i < NUM_CNT; i++) wake_cnt[i] = wake_cnt[i] + 1'b1;
        if (ticks_for(full_now()) <= wake_cnt[CNT_FULL]) begin
          clear_counts();
          res.reason = WR_FULL;
        end else if (ticks_for(reg_val[REG_SNOOZE]) <= wake_cnt[CNT_SNOOZE]) begin
          wake_cnt[CNT_SNOOZE] = '0;
          wake_cnt[CNT_ENVSND] = '0;
          wake_cnt[CNT_ALERT]  = '0;
          wake_cnt[CNT_ENVLOG] = '0;
          res.reason = WR_SNOOZE;
        end else if (ticks_for(reg_val[REG_ENV_SEND]) <= wake_cnt[CNT_ENVSND]) begin
          wake_cnt[CNT_ENVSND] = '0;
          wake_cnt[CNT_ALERT]  = '0;
          wake_cnt[CNT_ENVLOG] = '0;
          res.reason = WR_ENV_SEND;
        end else if (ticks_for(reg_val[REG_ALERT]) <= wake_cnt[CNT_ALERT]) begin
          res.reason = WR_ALERT;
        end else if (ticks_for(reg_val[REG_ENV_LOG]) == wake_cnt[CNT_ENVLOG]) begin
          wake_cnt[CNT_ENVLOG] = '0;
          res.reason = WR_ENV_LOG;
        end else begin
          res.reason = WR_SLEEP;
          res.action = PA_SLEEP;
        end
      end
      FUNC_COLD: begin
        clear_counts();
        nap_idx  = '0;
        ovr_on   = 1'b0;
        ovr_secs = '0;
      end
      FUNC_ANOMALY: begin
        if (nap_idx < STEPS_USED) begin
          sel = nap_idx;
          nap_idx = nap_idx + 1'b1;
        end else begin
          sel = STEPS_USED - 1;
        end
        ovr_secs = OVR_W'(SEC_PER_MIN * NAP_MINUTES[sel]);
        ovr_on   = 1'b1;
        case (kind)
          KIND_LINK_FAIL, KIND_IN_MOTION: begin
            clear_counts();
            res.reason = WR_SLEEP;
            res.action = PA_SLEEP;
          end
          KIND_EMPTY, KIND_SHORT_IGN, KIND_LOW_BATT, KIND_CHG_REM, KIND_SHUTDOWN: begin
            res.action = PA_OFF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.full_ivl = full_now();
    return res;
  endfunction

  // sender side: one word, with a random gap in front of it
  task automatic send_word(logic [1:0] func, logic [2:0] kind, logic typed,
                           wake_result_t want);
    int gap;
    wake_result_t got;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    got = advance_schedule(func, kind);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= next_reg[i];
      reg_val[i]   = next_reg[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_interval(logic [15:0] unit);
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (unit == 16'd0) return 16'($urandom_range(2000));
    return 16'(unit * $urandom_range(1, 30) + $urandom_range(0, unit - 1));
  endfunction

  function automatic void choose_regs(int phase);
    case (phase)
      0: begin
        next_reg[REG_WAKE_UNIT] = 16'd0;
        for (int i = 1; i < NUM_REGS; i++) next_reg[i] = pick_interval(16'd0);
      end
      1: begin
        for (int i = 0; i < NUM_REGS; i++) next_reg[i] = 16'hFFFF;
      end
      2: begin
        next_reg[REG_WAKE_UNIT] = 16'd1;
        next_reg[REG_FULL_INT]  = 16'hFFFF;
        next_reg[REG_SNOOZE]    = 16'hFFFF;
        next_reg[REG_ENV_SEND]  = 16'hFFFF;
        next_reg[REG_ALERT]     = 16'd0;
        next_reg[REG_ENV_LOG]   = 16'hFFFF;
      end
      3: begin
        next_reg[REG_WAKE_UNIT] = 16'($urandom_range(1, 65535));
        for (int i = 1; i < NUM_REGS; i++) next_reg[i] = 16'($urandom_range(65535));
      end
      default: begin
        next_reg[REG_WAKE_UNIT] = 16'($urandom_range(1, 60));
        for (int i = 1; i < NUM_REGS; i++) next_reg[i] = pick_interval(next_reg[REG_WAKE_UNIT]);
      end
    endcase
  endfunction

  // receiver side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    wake_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.reason) begin
          $error("wake_reason: expected %0d, got %0d", want.reason, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[4:3] !== want.action) begin
          $error("power_action: expected %0d, got %0d", want.action, m_axis_tdata[4:3]);
          errors++;
        end
        if (m_axis_tdata[20:5] !== want.full_ivl) begin
          $error("current_full_interval: expected %0d, got %0d",
                 want.full_ivl, m_axis_tdata[20:5]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  plan_row_t plan [DIRECTED_ROWS] = '{
    '{FUNC_TICK,    KIND_NONE,      1'b1, '{WR_SLEEP,  PA_SLEEP, 16'd300}},
    '{FUNC_IGNORED, KIND_UNUSED,    1'b1, '{WR_NORMAL, PA_NONE,  16'd300}},
    '{FUNC_COLD,    KIND_NONE,      1'b1, '{WR_NORMAL, PA_NONE,  16'd300}},
    '{FUNC_ANOMALY, KIND_UNUSED,    1'b1, '{WR_NORMAL, PA_NONE,  16'd120}},
    '{FUNC_ANOMALY, KIND_LINK_FAIL, 1'b1, '{WR_SLEEP,  PA_SLEEP, 16'd240}},
    '{FUNC_ANOMALY, KIND_IN_MOTION, 1'b1, '{WR_SLEEP,  PA_SLEEP, 16'd480}},
    '{FUNC_ANOMALY, KIND_EMPTY,     1'b1, '{WR_NORMAL, PA_OFF,   16'd960}},
    '{FUNC_ANOMALY, KIND_SHORT_IGN, 1'b1, '{WR_NORMAL, PA_OFF,   16'd1920}},
    '{FUNC_ANOMALY, KIND_LOW_BATT,  1'b1, '{WR_NORMAL, PA_OFF,   16'd3600}},
    '{FUNC_ANOMALY, KIND_CHG_REM,   1'b1, '{WR_NORMAL, PA_OFF,   16'd7200}},
    '{FUNC_ANOMALY, KIND_SHUTDOWN,  1'b1, '{WR_NORMAL, PA_OFF,   16'd7200}},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_COLD,    KIND_NONE,      1'b1, '{WR_NORMAL, PA_NONE,  16'd300}},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY},
    '{FUNC_TICK,    KIND_NONE,      1'b0, ANY}
  };

  initial begin
    int unsigned pick;
    logic [1:0] func;
    logic [2:0] kind;
    reset_schedule();
    src_idle_pct = 37;
    dst_idle_pct = 45;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_word(plan[i].func, plan[i].kind, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 5) begin
        src_idle_pct = 37;
        dst_idle_pct = 45;
      end else if (phase < 10) begin
        src_idle_pct = 45;
        dst_idle_pct = 37;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      // registers change only with the pipe empty
      wait_drained();
      choose_regs(phase);
      program_regs();
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        kind = 3'($urandom_range(7));
        if (pick < 76) func = FUNC_TICK;
        else if (pick < 88) func = FUNC_ANOMALY;
        else if (pick < 94) func = FUNC_COLD;
        else func = FUNC_IGNORED;
        send_word(func, kind, 1'b0, ANY);
        if ($urandom_range(149) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
